@@ design/flt_pkg.sv @@
// shared types for the fraction lowest-terms block
package flt_pkg;

   // status flag carried with each result: 1 reduced, 0 zero denominator
   typedef logic ok_flag_type;

   localparam ok_flag_type OK_REDUCED   = 1'b1;
   localparam ok_flag_type OK_REJECTED  = 1'b0;

endpackage

@@ design/flt_req_if.sv @@
// request channel: signed numerator and denominator with valid/ready
interface flt_req_if #(
   parameter int WIDTH = 32
) ();
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] num_in;
   logic signed [WIDTH-1:0] den_in;

   modport source (output valid, output num_in, output den_in, input ready);
   modport sink   (input valid, input num_in, input den_in, output ready);
endinterface

@@ design/flt_rsp_if.sv @@
// response channel: ok flag and reduced fraction with valid/ready
interface flt_rsp_if
   import flt_pkg::*;
#(
   parameter int WIDTH = 32
) ();
   logic                    valid;
   logic                    ready;
   ok_flag_type             ok;
   logic signed [WIDTH-1:0] num_out;
   logic signed [WIDTH-1:0] den_out;

   modport source (output valid, output ok, output num_out, output den_out, input ready);
   modport sink   (input valid, input ok, input num_out, input den_out, output ready);
endinterface

@@ design/fraction_lowest_terms_top.sv @@
// fraction reduction to lowest terms by binary gcd and restoring division
//
//   channel    dir   handshake      payload
//   req_chan   in    valid/ready    num_in, den_in (signed, WIDTH bits)
//   rsp_chan   out   valid/ready    ok, num_out, den_out (signed, WIDTH bits)
//
// one item at a time: a zero numerator or zero denominator goes straight to
// the last step; otherwise the block strips the common twos, runs the gcd loop
// and then computes both quotients in parallel, using the single-step gcd unit
// and the bit-per-cycle divider.
// reset is synchronous and clears the sequencer and the response valid.
// a result waits in the output register while req_chan takes the next item;
// the sequencer holds in its last step until that register is free.
module fraction_lowest_terms_top
   import flt_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input logic      clock,
   input logic      reset,
   flt_req_if.sink  req_chan,
   flt_rsp_if.source rsp_chan
);

   localparam int KW = $clog2(WIDTH);
   localparam int CW = $clog2(WIDTH + 1);
   localparam logic [CW-1:0] LAST_BIT = CW'(WIDTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_TWOS,
      ST_GCD,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [WIDTH-1:0]   a_ff, a_in;     // gcd operand, later numerator remainder
   logic [WIDTH-1:0]   b_ff, b_in;     // gcd operand, later denominator remainder
   logic [WIDTH-1:0]   qn_ff, qn_in;   // numerator: raw, magnitude, then quotient
   logic [WIDTH-1:0]   qd_ff, qd_in;   // denominator: raw, magnitude, then quotient
   logic [WIDTH-1:0]   g_ff, g_in;     // common divisor
   logic [KW-1:0]      k_ff, k_in;     // shared power of two
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               nneg_ff, nneg_in;
   logic               dneg_ff, dneg_in;
   ok_flag_type        ok_ff, ok_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ok_flag_type        rsp_ok_ff, rsp_ok_in;
   logic [WIDTH-1:0]   rsp_num_ff, rsp_num_in;
   logic [WIDTH-1:0]   rsp_den_ff, rsp_den_in;

   // gcd step datapath: one compare and one subtract
   logic               a_gt_b;
   logic [WIDTH-1:0]   big_op, small_op, gcd_diff;
   // divider lanes
   logic [WIDTH:0]     sh_n, sh_d, dif_n, dif_d;
   // sign handling
   logic [WIDTH-1:0]   mag_n, mag_d, out_n, out_d;
   logic               out_free;

   assign a_gt_b   = a_ff > b_ff;
   assign big_op   = a_gt_b ? a_ff : b_ff;
   assign small_op = a_gt_b ? b_ff : a_ff;
   assign gcd_diff = big_op - small_op;

   assign sh_n  = {a_ff, qn_ff[WIDTH-1]};
   assign sh_d  = {b_ff, qd_ff[WIDTH-1]};
   assign dif_n = sh_n - {1'b0, g_ff};
   assign dif_d = sh_d - {1'b0, g_ff};

   assign mag_n = qn_ff[WIDTH-1] ? (WIDTH'(0) - qn_ff) : qn_ff;
   assign mag_d = qd_ff[WIDTH-1] ? (WIDTH'(0) - qd_ff) : qd_ff;
   assign out_n = nneg_ff ? (WIDTH'(0) - qn_ff) : qn_ff;
   assign out_d = dneg_ff ? (WIDTH'(0) - qd_ff) : qd_ff;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      qn_in        = qn_ff;
      qd_in        = qd_ff;
      g_in         = g_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      nneg_in      = nneg_ff;
      dneg_in      = dneg_ff;
      ok_in        = ok_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               qn_in    = req_chan.num_in;
               qd_in    = req_chan.den_in;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            // zero denominator or zero numerator: values go out unchanged
            if (qd_ff == '0 || qn_ff == '0) begin
               ok_in    = (qd_ff == '0) ? OK_REJECTED : OK_REDUCED;
               nneg_in  = 1'b0;
               dneg_in  = 1'b0;
               state_in = ST_DONE;
            end else begin
               ok_in    = OK_REDUCED;
               nneg_in  = qn_ff[WIDTH-1];
               dneg_in  = qd_ff[WIDTH-1];
               qn_in    = mag_n;
               qd_in    = mag_d;
               a_in     = mag_n;
               b_in     = mag_d;
               k_in     = '0;
               state_in = ST_TWOS;
            end
         end
         ST_TWOS: begin
            // strip factors of two common to both
            if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + KW'(1);
            end else begin
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            // binary gcd: shift out twos, then subtract smaller from larger
            if (b_ff == '0) begin
               g_in     = a_ff << k_ff;
               a_in     = '0;
               b_in     = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else begin
               a_in = small_op;
               b_in = gcd_diff;
            end
         end
         ST_DIV: begin
            // one quotient bit per cycle for both magnitudes
            if (!dif_n[WIDTH]) begin
               a_in  = dif_n[WIDTH-1:0];
               qn_in = {qn_ff[WIDTH-2:0], 1'b1};
            end else begin
               a_in  = sh_n[WIDTH-1:0];
               qn_in = {qn_ff[WIDTH-2:0], 1'b0};
            end
            if (!dif_d[WIDTH]) begin
               b_in  = dif_d[WIDTH-1:0];
               qd_in = {qd_ff[WIDTH-2:0], 1'b1};
            end else begin
               b_in  = sh_d[WIDTH-1:0];
               qd_in = {qd_ff[WIDTH-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == LAST_BIT) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // restore signs and hand off once the output register is free
            if (out_free) begin
               rsp_ok_in    = ok_ff;
               rsp_num_in   = out_n;
               rsp_den_in   = out_d;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff       <= a_in;
      b_ff       <= b_in;
      qn_ff      <= qn_in;
      qd_ff      <= qd_in;
      g_ff       <= g_in;
      k_ff       <= k_in;
      cnt_ff     <= cnt_in;
      nneg_ff    <= nneg_in;
      dneg_ff    <= dneg_in;
      ok_ff      <= ok_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
   end

   // channel drive
   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.ok      = rsp_ok_ff;
   assign rsp_chan.num_out = rsp_num_ff;
   assign rsp_chan.den_out = rsp_den_ff;

endmodule
